@@ rtl/core/sorted_table_insert_search_assert.svh @@
// Assertion macros for the sorted key table.
`ifndef SORTED_TABLE_INSERT_SEARCH_ASSERT_SVH
`define SORTED_TABLE_INSERT_SEARCH_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define STI_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sti assertion failed");
// next-cycle implication
`define STI_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sti assertion failed");
`else
`define STI_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define STI_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

@@ rtl/core/sti_pkg.sv @@
// Shared types and constants for the sorted key table.
`timescale 1ns / 1ps
package sti_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int KEY_W       = 32;
    localparam int POS_W       = 10;
    localparam int CMPS_W      = 11;
    localparam int MODE_W      = 2;
    localparam int STATUS_W    = 2;
    localparam int ODATA_W     = 24;

    typedef logic signed [KEY_W-1:0] t_key;

    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT  = 2'd0,
        MODE_BSEARCH = 2'd1,
        MODE_LSEARCH = 2'd2,
        MODE_TSEARCH = 2'd3
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_EMPTY     = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS,
        S_INS_WR,
        S_BS_CHK,
        S_BS_CMP,
        S_LIN,
        S_TR,
        S_TR_WR,
        S_OUT
    } t_state;

    typedef struct packed {
        logic lt;
        logic eq;
        logic gt;
    } t_cmp_res;

endpackage

@@ rtl/core/sorted_table_insert_search.sv @@
// Sorted key table: insert, binary, linear and transpose search.
// One request at a time; the table RAM has one read and one write port.
// A full table on insert and an empty table on linear or transpose search are answered
// without a table read; a transpose hit first swaps the key with its predecessor.
// A new request is taken only once the last result has entered the output register, later while it is held.
// Reset clears the entry count and sets keep_sorted; table contents are not cleared.
`timescale 1ns / 1ps
`include "sorted_table_insert_search_assert.svh"
module sorted_table_insert_search (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic                             i_cfg_wdata,   // keep_sorted
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [sti_pkg::KEY_W-1:0]        s_axis_tdata,  // [31:0] key
    input  logic [sti_pkg::MODE_W-1:0]       s_axis_tuser,  // [1:0] mode
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [sti_pkg::ODATA_W-1:0]      m_axis_tdata,  // [9:0] position, [20:10] comparisons
    output logic [sti_pkg::STATUS_W-1:0]     m_axis_tuser   // [1:0] status
);
    import sti_pkg::*;

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_count, n_count;
    logic                r_keep_sorted;
    t_key                r_key, n_key;
    t_mode               r_mode, n_mode;
    logic [ADDR_W-1:0]   r_idx, n_idx;
    logic [CNT_W-1:0]    r_lo, n_lo;
    logic [CNT_W-1:0]    r_hx, n_hx;
    logic [CMPS_W-1:0]   r_cmps, n_cmps;
    t_status             r_res_status, n_res_status;
    logic [POS_W-1:0]    r_res_pos, n_res_pos;
    logic                r_m_valid, n_m_valid;
    t_status             r_m_status, n_m_status;
    logic [POS_W-1:0]    r_m_pos, n_m_pos;
    logic [CMPS_W-1:0]   r_m_cmps, n_m_cmps;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    t_key                ram_wdata;
    logic                ram_re;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [KEY_W-1:0]    ram_rdata;
    t_cmp_res            cmp_res;
    logic [CNT_W:0]      mid_sum;

    sti_ram #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (KEY_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    sti_cmp u_cmp (
        .i_a   (t_key'(ram_rdata)),
        .i_b   (r_key),
        .o_res (cmp_res)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_m_status;
    assign m_axis_tdata  = {{(ODATA_W - CMPS_W - POS_W){1'b0}}, r_m_cmps, r_m_pos};

    // midpoint of [lo, hx-1]
    assign mid_sum = ({1'b0, r_lo} + {1'b0, r_hx} - (CNT_W+1)'(1)) >> 1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_count       <= '0;
            r_keep_sorted <= 1'b1;
            r_m_valid     <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_m_valid <= n_m_valid;
            if (i_cfg_we) begin
                r_keep_sorted <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_key        <= n_key;
        r_mode       <= n_mode;
        r_idx        <= n_idx;
        r_lo         <= n_lo;
        r_hx         <= n_hx;
        r_cmps       <= n_cmps;
        r_res_status <= n_res_status;
        r_res_pos    <= n_res_pos;
        r_m_status   <= n_m_status;
        r_m_pos      <= n_m_pos;
        r_m_cmps     <= n_m_cmps;
    end

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_key        = r_key;
        n_mode       = r_mode;
        n_idx        = r_idx;
        n_lo         = r_lo;
        n_hx         = r_hx;
        n_cmps       = r_cmps;
        n_res_status = r_res_status;
        n_res_pos    = r_res_pos;
        n_m_valid    = r_m_valid && !m_axis_tready;
        n_m_status   = r_m_status;
        n_m_pos      = r_m_pos;
        n_m_cmps     = r_m_cmps;
        ram_we       = 1'b0;
        ram_waddr    = r_idx;
        ram_wdata    = r_key;
        ram_re       = 1'b0;
        ram_raddr    = r_idx;

        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_key        = t_key'(s_axis_tdata);
                    n_mode       = t_mode'(s_axis_tuser);
                    n_cmps       = '0;
                    n_res_pos    = '0;
                    n_res_status = ST_OK;
                    unique case (t_mode'(s_axis_tuser))
                        MODE_INSERT: begin
                            n_idx = ADDR_W'(r_count);
                            if (r_count == CNT_W'(TABLE_DEPTH)) begin
                                n_res_status = ST_FULL;
                                n_state      = S_OUT;
                            end else if (r_keep_sorted && (r_count != '0)) begin
                                ram_re    = 1'b1;
                                ram_raddr = ADDR_W'(r_count - CNT_W'(1));
                                n_state   = S_INS;
                            end else begin
                                n_state = S_INS_WR;
                            end
                        end
                        MODE_BSEARCH: begin
                            n_lo    = '0;
                            n_hx    = r_count;
                            n_state = S_BS_CHK;
                        end
                        MODE_LSEARCH, MODE_TSEARCH: begin
                            n_idx = '0;
                            if (r_count == '0) begin
                                n_res_status = ST_EMPTY;
                                n_state      = S_OUT;
                            end else begin
                                ram_re    = 1'b1;
                                ram_raddr = '0;
                                n_state   = S_LIN;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_INS: begin
                n_cmps = r_cmps + CMPS_W'(1);
                if (cmp_res.gt) begin
                    // move larger key up, fetch the next one down
                    ram_we    = 1'b1;
                    ram_waddr = r_idx;
                    ram_wdata = t_key'(ram_rdata);
                    n_idx     = r_idx - ADDR_W'(1);
                    if (r_idx != ADDR_W'(1)) begin
                        ram_re    = 1'b1;
                        ram_raddr = r_idx - ADDR_W'(2);
                    end else begin
                        n_state = S_INS_WR;
                    end
                end else begin
                    n_state = S_INS_WR;
                end
            end
            S_INS_WR: begin
                ram_we       = 1'b1;
                ram_waddr    = r_idx;
                ram_wdata    = r_key;
                n_count      = r_count + CNT_W'(1);
                n_res_status = ST_OK;
                n_res_pos    = POS_W'(r_idx);
                n_state      = S_OUT;
            end
            S_BS_CHK: begin
                if (r_lo >= r_hx) begin
                    n_res_status = ST_NOT_FOUND;
                    n_res_pos    = '0;
                    n_state      = S_OUT;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = ADDR_W'(mid_sum);
                    n_idx     = ADDR_W'(mid_sum);
                    n_state   = S_BS_CMP;
                end
            end
            S_BS_CMP: begin
                n_state = S_BS_CHK;
                if (cmp_res.lt) begin
                    n_cmps = r_cmps + CMPS_W'(1);
                    n_lo   = CNT_W'(r_idx) + CNT_W'(1);
                end else begin
                    n_cmps = r_cmps + CMPS_W'(2);
                    if (cmp_res.gt) begin
                        n_hx = CNT_W'(r_idx);
                    end else begin
                        n_res_status = ST_OK;
                        n_res_pos    = POS_W'(r_idx);
                        n_state      = S_OUT;
                    end
                end
            end
            S_LIN: begin
                n_cmps = r_cmps + CMPS_W'(1);
                if (cmp_res.eq) begin
                    if ((r_mode == MODE_TSEARCH) && (r_idx != '0)) begin
                        ram_re    = 1'b1;
                        ram_raddr = r_idx - ADDR_W'(1);
                        n_state   = S_TR;
                    end else begin
                        n_res_status = ST_OK;
                        n_res_pos    = POS_W'(r_idx);
                        n_state      = S_OUT;
                    end
                end else if ((CNT_W'(r_idx) + CNT_W'(1)) == r_count) begin
                    n_res_status = ST_NOT_FOUND;
                    n_res_pos    = '0;
                    n_state      = S_OUT;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = r_idx + ADDR_W'(1);
                    n_idx     = r_idx + ADDR_W'(1);
                end
            end
            S_TR: begin
                // predecessor moves up into the found slot
                ram_we    = 1'b1;
                ram_waddr = r_idx;
                ram_wdata = t_key'(ram_rdata);
                n_idx     = r_idx - ADDR_W'(1);
                n_state   = S_TR_WR;
            end
            S_TR_WR: begin
                ram_we       = 1'b1;
                ram_waddr    = r_idx;
                ram_wdata    = r_key;
                n_res_status = ST_OK;
                n_res_pos    = POS_W'(r_idx);
                n_state      = S_OUT;
            end
            S_OUT: begin
                if (!r_m_valid || m_axis_tready) begin
                    n_m_valid  = 1'b1;
                    n_m_status = r_res_status;
                    n_m_pos    = r_res_pos;
                    n_m_cmps   = r_cmps;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    `STI_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(TABLE_DEPTH))
    `STI_ASSERT_IMP(a_write_states, i_clk, i_rst_n, ram_we,
        (r_state == S_INS) || (r_state == S_INS_WR) || (r_state == S_TR) || (r_state == S_TR_WR))
    `STI_ASSERT_IMP(a_read_in_table, i_clk, i_rst_n, ram_re && (r_state != S_IDLE),
        CNT_W'(ram_raddr) < r_count)
    `STI_ASSERT_NXT(a_count_on_insert, i_clk, i_rst_n, r_state != S_INS_WR, $stable(r_count))
    `STI_ASSERT_IMP(a_out_only_from_out, i_clk, i_rst_n, n_m_valid && !r_m_valid, r_state == S_OUT)
endmodule

@@ rtl/core/sti_ram.sv @@
// Simple dual-port RAM, one write and one registered read port.
`timescale 1ns / 1ps
module sti_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end
endmodule

@@ rtl/core/sti_cmp.sv @@
// Shared signed key comparator.
`timescale 1ns / 1ps
module sti_cmp (
    input  sti_pkg::t_key     i_a,
    input  sti_pkg::t_key     i_b,
    output sti_pkg::t_cmp_res o_res
);
    import sti_pkg::*;

    always_comb begin
        o_res.lt = (i_a < i_b);
        o_res.eq = (i_a == i_b);
        o_res.gt = (i_a > i_b);
    end
endmodule

@@ verif/sorted_table_insert_search_tb.sv @@
// Self-checking testbench for the sorted key table: directed, random, backpressure and long table.
`timescale 1ns / 1ps
module sorted_table_insert_search_tb;
    import sti_pkg::*;

    localparam int CYCLE_LIMIT = 10_000_000;
    localparam int LONG_FILL   = 300;

    typedef struct {
        t_status             status;
        logic [POS_W-1:0]    position;
        logic [CMPS_W-1:0]   comparisons;
    } t_table_reply;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                i_cfg_we      = 1'b0;
    logic                i_cfg_wdata   = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [KEY_W-1:0]    s_axis_tdata  = '0;   // [31:0] key
    logic [MODE_W-1:0]   s_axis_tuser  = '0;   // [1:0] mode
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [ODATA_W-1:0]  m_axis_tdata;          // [9:0] position, [20:10] comparisons
    logic [STATUS_W-1:0] m_axis_tuser;          // [1:0] status

    // shadow copy of the table and its settings
    t_key         shadow_keys [TABLE_DEPTH];
    int           stored_count = 0;
    bit           sorted_mode  = 1'b1;

    t_table_reply expected_replies[$];
    int           mismatch_count  = 0;
    int           replies_checked = 0;
    int           request_total   = 0;
    int           idle_pct        = 21;
    int           stall_left      = 0;
    int           cycle_count     = 0;

    sorted_table_insert_search DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    // Applies one request to the shadow table and returns the reply it should give.
    function automatic t_table_reply predict_table_reply(input t_mode req_mode,
                                                         input t_key req_key);
        t_table_reply r;
        int n, i, lo, hi, mid;
        r.status      = ST_OK;
        r.position    = '0;
        r.comparisons = '0;
        n = stored_count;
        case (req_mode)
            MODE_INSERT: begin
                if (n >= TABLE_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    i = n;
                    if (sorted_mode) begin
                        while (i > 0) begin
                            r.comparisons++;
                            if (shadow_keys[i-1] > req_key) begin
                                shadow_keys[i] = shadow_keys[i-1];
                                i--;
                            end else begin
                                break;
                            end
                        end
                    end
                    shadow_keys[i] = req_key;
                    stored_count   = n + 1;
                    r.position     = i[POS_W-1:0];
                end
            end
            MODE_BSEARCH: begin
                lo = 0;
                hi = n - 1;
                while (lo <= hi) begin
                    mid = (lo + hi) / 2;
                    r.comparisons++;
                    if (shadow_keys[mid] < req_key) begin
                        lo = mid + 1;
                    end else begin
                        r.comparisons++;
                        if (shadow_keys[mid] > req_key) begin
                            hi = mid - 1;
                        end else begin
                            r.position = mid[POS_W-1:0];
                            return r;
                        end
                    end
                end
                r.status = ST_NOT_FOUND;
            end
            default: begin
                if (n == 0) begin
                    r.status = ST_EMPTY;
                    return r;
                end
                for (i = 0; i < n; i++) begin
                    r.comparisons++;
                    if (shadow_keys[i] == req_key) begin
                        // transpose moves a hit one slot toward the front
                        if (req_mode == MODE_TSEARCH && i > 0) begin
                            shadow_keys[i]   = shadow_keys[i-1];
                            shadow_keys[i-1] = req_key;
                            i--;
                        end
                        r.position = i[POS_W-1:0];
                        return r;
                    end
                end
                r.status = ST_NOT_FOUND;
            end
        endcase
        return r;
    endfunction

    // Half the time a key already stored (if any), else a small or a full-range one.
    function automatic t_key pick_key();
        int unsigned sel;
        sel = $urandom_range(99);
        if (stored_count > 0 && sel < 50)
            return shadow_keys[$urandom_range(stored_count - 1)];
        if (sel < 75)
            return t_key'(int'($urandom_range(16)) - 8);
        return t_key'($urandom);
    endfunction

    // Reply checker and receiver-side ready generation.
    always @(posedge i_clk) begin
        t_table_reply want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_replies.size() == 0) begin
                    $error("reply with no request pending: status %0d data %h",
                           m_axis_tuser, m_axis_tdata);
                    mismatch_count++;
                end else begin
                    want = expected_replies.pop_front();
                    replies_checked++;
                    if (m_axis_tuser !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
                        mismatch_count++;
                    end
                    if (m_axis_tdata[9:0] !== want.position) begin
                        $error("position: expected %0d, got %0d",
                               want.position, m_axis_tdata[9:0]);
                        mismatch_count++;
                    end
                    if (m_axis_tdata[20:10] !== want.comparisons) begin
                        $error("comparisons: expected %0d, got %0d",
                               want.comparisons, m_axis_tdata[20:10]);
                        mismatch_count++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= idle_pct);
            end
        end
    end

    // Valid is left high on return so back-to-back requests need no re-raise.
    task automatic send_request(input t_mode req_mode, input t_key req_key);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= req_key;
        s_axis_tuser  <= req_mode;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        expected_replies.push_back(predict_table_reply(req_mode, req_key));
        request_total++;
    endtask

    task automatic wait_for_replies();
        s_axis_tvalid <= 1'b0;
        while (expected_replies.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_keep_sorted(input bit value);
        wait_for_replies();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sorted_mode = value;
    endtask

    task automatic test_empty_table();
        send_request(MODE_BSEARCH, 0);
        send_request(MODE_LSEARCH, 5);
        send_request(MODE_TSEARCH, -5);
        wait_for_replies();
    endtask

    task automatic test_extreme_keys();
        write_keep_sorted(1'b1);
        send_request(MODE_INSERT, 0);
        send_request(MODE_INSERT, 32'sh7FFF_FFFF);
        send_request(MODE_INSERT, 32'sh8000_0000);
        send_request(MODE_INSERT, -1);
        send_request(MODE_INSERT, 1);
        send_request(MODE_INSERT, 0);
        send_request(MODE_BSEARCH, 32'sh8000_0000);
        send_request(MODE_BSEARCH, 32'sh7FFF_FFFF);
        send_request(MODE_BSEARCH, 2);
        send_request(MODE_LSEARCH, 32'sh8000_0000);
        wait_for_replies();
    endtask

    task automatic test_transpose();
        send_request(MODE_TSEARCH, 32'sh8000_0000);   // hit at the front, no swap
        send_request(MODE_TSEARCH, 32'sh7FFF_FFFF);
        send_request(MODE_LSEARCH, 32'sh7FFF_FFFF);
        send_request(MODE_BSEARCH, 32'sh7FFF_FFFF);   // table no longer sorted
        send_request(MODE_LSEARCH, 12345);
        wait_for_replies();
    endtask

    task automatic test_keep_sorted_toggle();
        write_keep_sorted(1'b0);
        send_request(MODE_INSERT, -100);
        send_request(MODE_INSERT, 7);
        write_keep_sorted(1'b1);
        // walks down from the end only, earlier unsorted keys stay put
        send_request(MODE_INSERT, -50);
        send_request(MODE_BSEARCH, -50);
        send_request(MODE_LSEARCH, -100);
        wait_for_replies();
    endtask

    task automatic test_random(input int count, input int insert_pct);
        t_mode m;
        repeat (count) begin
            if ($urandom_range(99) < insert_pct)
                m = MODE_INSERT;
            else
                m = t_mode'($urandom_range(3, 1));
            send_request(m, pick_key());
        end
        wait_for_replies();
    endtask

    task automatic test_backpressure();
        @(negedge i_clk);
        stall_left = 400;
        @(posedge i_clk);
        test_random(12, 40);
    endtask

    // Grows the table to a few hundred entries for long walks and misses.
    task automatic test_long_table();
        t_key absent;
        bit   clash;
        write_keep_sorted(1'b0);
        while (stored_count < LONG_FILL)
            send_request(MODE_INSERT, ($urandom_range(1)) ? t_key'($urandom) : pick_key());
        write_keep_sorted(1'b1);
        send_request(MODE_INSERT, -1);
        do begin
            absent = t_key'($urandom);
            clash  = 1'b0;
            for (int j = 0; j < stored_count; j++)
                if (shadow_keys[j] == absent) clash = 1'b1;
        end while (clash);
        send_request(MODE_LSEARCH, absent);
        send_request(MODE_TSEARCH, absent);
        send_request(MODE_BSEARCH, absent);
        send_request(MODE_TSEARCH, shadow_keys[stored_count-1]);
        send_request(MODE_LSEARCH, shadow_keys[stored_count-1]);
        test_random(10, 20);
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_table();
        test_extreme_keys();
        test_transpose();
        test_keep_sorted_toggle();
        test_random(140, 40);
        write_keep_sorted(1'b0);
        test_random(80, 45);
        write_keep_sorted(1'b1);
        idle_pct = 0;
        test_random(80, 35);
        idle_pct = 21;
        test_backpressure();
        test_random(60, 40);
        test_long_table();
        wait_for_replies();
        repeat (30) @(posedge i_clk);
        $display("Ran %0d requests (%0d replies checked) over all four modes,", request_total,
                 replies_checked);
        $display("both table orderings, empty and %0d-entry tables, idle gaps and a long stall.",
                 LONG_FILL);
        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
